FILE: sv/imhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_pkg
// Types and constants shared by the indexed min-heap queue, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VTX_BITS     = 8;
  localparam int DIST_BITS    = 32;
  localparam int POS_BITS     = 9;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [VTX_BITS-1:0]  vtx_t;
  typedef logic [POS_BITS-1:0]  pos_t;

  localparam dist_t DIST_INF = {DIST_BITS{1'b1}};
  localparam pos_t  POS_MAX  = pos_t'(MAX_VERTICES);

  // operation codes
  typedef enum logic [1:0] {
    OP_RESTART  = 2'd0,
    OP_DECREASE = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_QUEUED = 3'd2,
    ST_NOT_DEC    = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  // one heap slot
  typedef struct packed {
    vtx_t  vtx;
    dist_t key;
  } heap_entry_t;

endpackage
`default_nettype wire

FILE: sv/imhq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_req_if
// Request channel of the heap queue: operation, vertex and new distance.
// ----------------------------------------------------------------------------
interface imhq_req_if;
  logic               valid;
  logic               ready;
  imhq_pkg::op_t      op;
  imhq_pkg::vtx_t     vertex;
  imhq_pkg::dist_t    new_distance;

  modport source (output valid, output op, output vertex, output new_distance,
                  input ready);
  modport sink   (input valid, input op, input vertex, input new_distance,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/imhq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_rsp_if
// Response channel of the heap queue: status, vertex, distance, queued flag
// and remaining size.
// ----------------------------------------------------------------------------
interface imhq_rsp_if;
  logic               valid;
  logic               ready;
  imhq_pkg::status_t  status;
  imhq_pkg::vtx_t     result_vertex;
  imhq_pkg::dist_t    result_distance;
  logic               queued;
  imhq_pkg::pos_t     remaining;

  modport source (output valid, output status, output result_vertex,
                  output result_distance, output queued, output remaining,
                  input ready);
  modport sink   (input valid, input status, input result_vertex,
                  input result_distance, input queued, input remaining,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/indexed_min_heap_queue.sv
// Indexed binary min-heap of up to 256 vertices keyed by 32-bit distance,
// with a vertex-to-position map, for shortest-path searches. One request is
// worked at a time; req.ready is high only while the block is idle, and a
// finished response waits in an output register so the next request can be
// taken meanwhile. A single sequencer drives one heap memory (one write, two
// registered reads per cycle) and one position memory, with one or two key
// compares per cycle. A range fault or an empty remove is answered from the
// idle state, a vertex that is not queued after the position read, and a
// lookup or a rejected increase after the heap read as well. Decrease key then
// climbs with one parent read and compare per level until it settles or
// reaches the root. Remove nearest takes the root out and, unless that empties
// the queue, sinks the last entry from the root, reading both children per
// level. Restart sweeps all 256 slots, one per cycle. A response that is not
// taken holds the next one back. The vertex_count register may only be
// written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed min-heap priority queue with restart, decrease key, remove nearest
// and lookup, built around one sequencer and two memories.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [imhq_pkg::POS_BITS-1:0] cfg_data,
  imhq_req_if.sink    req,
  imhq_rsp_if.source  rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESTART,
    S_RM_RD,
    S_SD_ISSUE,
    S_SD_CMP,
    S_PM_RD,
    S_HP_RD,
    S_SU_ISSUE,
    S_SU_CMP,
    S_DONE
  } state_t;

  // memories
  imhq_pkg::heap_entry_t heap_mem [imhq_pkg::MAX_VERTICES];
  imhq_pkg::pos_t        pos_mem  [imhq_pkg::MAX_VERTICES];
  logic [imhq_pkg::MAX_VERTICES-1:0] pos_vld;

  // memory ports
  logic                  heap_we;
  imhq_pkg::vtx_t        heap_wa, heap_ra_a, heap_ra_b;
  imhq_pkg::heap_entry_t heap_wd, heap_rd_a, heap_rd_b;
  logic                  pos_we;
  imhq_pkg::vtx_t        pos_wa, pos_ra;
  imhq_pkg::pos_t        pos_wd, pos_rd;
  logic                  pos_vld_rd;

  // control and datapath registers
  state_t                state, state_next;
  imhq_pkg::op_t         op_r, op_r_next;
  imhq_pkg::vtx_t        vtx_r, vtx_r_next;
  imhq_pkg::dist_t       nd_r, nd_r_next;
  imhq_pkg::pos_t        p, p_next;
  imhq_pkg::pos_t        size, size_next;
  imhq_pkg::pos_t        vcount;
  imhq_pkg::vtx_t        cnt, cnt_next;
  imhq_pkg::heap_entry_t last, last_next;
  imhq_pkg::status_t     res_status, res_status_next;
  imhq_pkg::vtx_t        res_vtx, res_vtx_next;
  imhq_pkg::dist_t       res_dist, res_dist_next;
  logic                  res_queued, res_queued_next;

  // address arithmetic
  imhq_pkg::pos_t        limit;
  imhq_pkg::pos_t        size_m1, p_m1, par, par_m1, pval;
  logic [imhq_pkg::POS_BITS:0] p2, lc_pos_m1, cpos;
  logic                  has_left, has_right, pick_right, rsp_free;
  imhq_pkg::heap_entry_t child;

  assign limit      = (vcount > imhq_pkg::POS_MAX) ? imhq_pkg::POS_MAX : vcount;
  assign size_m1    = size - imhq_pkg::pos_t'(1);
  assign p_m1       = p - imhq_pkg::pos_t'(1);
  assign par        = {1'b0, p[imhq_pkg::POS_BITS-1:1]};
  assign par_m1     = par - imhq_pkg::pos_t'(1);
  assign p2         = {p, 1'b0};
  assign lc_pos_m1  = p2 - (imhq_pkg::POS_BITS+1)'(1);
  assign has_left   = p2 <= {1'b0, size};
  assign has_right  = p2 < {1'b0, size};
  assign pick_right = has_right && (heap_rd_b.key < heap_rd_a.key);
  assign child      = pick_right ? heap_rd_b : heap_rd_a;
  assign cpos       = p2 + {{imhq_pkg::POS_BITS{1'b0}}, pick_right};
  assign pval       = pos_vld_rd ? pos_rd : '0;
  assign rsp_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);

  // heap memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd_a <= heap_mem[heap_ra_a];
    heap_rd_b <= heap_mem[heap_ra_b];
  end

  // position memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd <= pos_mem[pos_ra];
  end

  // position valid bits, an unwritten entry reads as not queued
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld    <= '0;
      pos_vld_rd <= 1'b0;
    end else begin
      if (pos_we) begin
        pos_vld[pos_wa] <= 1'b1;
      end
      pos_vld_rd <= pos_vld[pos_ra];
    end
  end

  // sequencer next state and memory strobes
  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    vtx_r_next      = vtx_r;
    nd_r_next       = nd_r;
    p_next          = p;
    size_next       = size;
    cnt_next        = cnt;
    last_next       = last;
    res_status_next = res_status;
    res_vtx_next    = res_vtx;
    res_dist_next   = res_dist;
    res_queued_next = res_queued;
    heap_we         = 1'b0;
    heap_wa         = '0;
    heap_wd         = '0;
    heap_ra_a       = '0;
    heap_ra_b       = '0;
    pos_we          = 1'b0;
    pos_wa          = '0;
    pos_wd          = '0;
    pos_ra          = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_r_next  = req.op;
          vtx_r_next = req.vertex;
          nd_r_next  = req.new_distance;
          unique case (req.op)
            imhq_pkg::OP_RESTART: begin
              cnt_next   = '0;
              state_next = S_RESTART;
            end
            imhq_pkg::OP_REMOVE: begin
              if (size == '0) begin
                res_status_next = imhq_pkg::ST_EMPTY;
                res_vtx_next    = '0;
                res_dist_next   = imhq_pkg::DIST_INF;
                res_queued_next = 1'b0;
                state_next      = S_DONE;
              end else begin
                heap_ra_a  = '0;
                heap_ra_b  = size_m1[imhq_pkg::VTX_BITS-1:0];
                state_next = S_RM_RD;
              end
            end
            default: begin
              if ({1'b0, req.vertex} >= limit) begin
                res_status_next = imhq_pkg::ST_RANGE;
                res_vtx_next    = req.vertex;
                res_dist_next   = imhq_pkg::DIST_INF;
                res_queued_next = 1'b0;
                state_next      = S_DONE;
              end else begin
                pos_ra     = req.vertex;
                state_next = S_PM_RD;
              end
            end
          endcase
        end
      end

      // load every vertex in use at infinite distance, clear the rest
      S_RESTART: begin
        pos_we = 1'b1;
        pos_wa = cnt;
        if ({1'b0, cnt} < limit) begin
          heap_we = 1'b1;
          heap_wa = cnt;
          heap_wd = '{vtx: cnt, key: imhq_pkg::DIST_INF};
          pos_wd  = {1'b0, cnt} + imhq_pkg::pos_t'(1);
        end
        cnt_next = cnt + imhq_pkg::vtx_t'(1);
        if (cnt == '1) begin
          size_next       = limit;
          res_status_next = imhq_pkg::ST_OK;
          res_vtx_next    = '0;
          res_dist_next   = imhq_pkg::DIST_INF;
          res_queued_next = 1'b0;
          state_next      = S_DONE;
        end
      end

      // root and last entry are in, take the root out
      S_RM_RD: begin
        last_next       = heap_rd_b;
        pos_we          = 1'b1;
        pos_wa          = heap_rd_a.vtx;
        pos_wd          = '0;
        size_next       = size_m1;
        res_status_next = imhq_pkg::ST_OK;
        res_vtx_next    = heap_rd_a.vtx;
        res_dist_next   = heap_rd_a.key;
        res_queued_next = 1'b0;
        p_next          = imhq_pkg::pos_t'(1);
        state_next      = (size_m1 == '0) ? S_DONE : S_SD_ISSUE;
      end

      // sift down: fetch both children, or settle the last entry here
      S_SD_ISSUE: begin
        if (has_left) begin
          heap_ra_a  = lc_pos_m1[imhq_pkg::VTX_BITS-1:0];
          heap_ra_b  = p2[imhq_pkg::VTX_BITS-1:0];
          state_next = S_SD_CMP;
        end else begin
          heap_we    = 1'b1;
          heap_wa    = p_m1[imhq_pkg::VTX_BITS-1:0];
          heap_wd    = last;
          pos_we     = 1'b1;
          pos_wa     = last.vtx;
          pos_wd     = p;
          state_next = S_DONE;
        end
      end

      // sift down: move the smaller child up or settle
      S_SD_CMP: begin
        heap_we = 1'b1;
        heap_wa = p_m1[imhq_pkg::VTX_BITS-1:0];
        pos_we  = 1'b1;
        pos_wd  = p;
        if (child.key < last.key) begin
          heap_wd    = child;
          pos_wa     = child.vtx;
          p_next     = cpos[imhq_pkg::POS_BITS-1:0];
          state_next = S_SD_ISSUE;
        end else begin
          heap_wd    = last;
          pos_wa     = last.vtx;
          state_next = S_DONE;
        end
      end

      // position of the named vertex is in
      S_PM_RD: begin
        if (pval == '0 || pval > size) begin
          res_status_next = (op_r == imhq_pkg::OP_DECREASE) ?
                            imhq_pkg::ST_NOT_QUEUED : imhq_pkg::ST_OK;
          res_vtx_next    = vtx_r;
          res_dist_next   = imhq_pkg::DIST_INF;
          res_queued_next = 1'b0;
          state_next      = S_DONE;
        end else begin
          p_next     = pval;
          heap_ra_a  = imhq_pkg::vtx_t'(pval - imhq_pkg::pos_t'(1));
          state_next = S_HP_RD;
        end
      end

      // current entry is in: report or check the decrease
      S_HP_RD: begin
        res_vtx_next    = vtx_r;
        res_queued_next = 1'b1;
        if (op_r == imhq_pkg::OP_LOOKUP) begin
          res_status_next = imhq_pkg::ST_OK;
          res_dist_next   = heap_rd_a.key;
          state_next      = S_DONE;
        end else if (nd_r > heap_rd_a.key) begin
          res_status_next = imhq_pkg::ST_NOT_DEC;
          res_dist_next   = heap_rd_a.key;
          state_next      = S_DONE;
        end else begin
          res_status_next = imhq_pkg::ST_OK;
          res_dist_next   = nd_r;
          state_next      = S_SU_ISSUE;
        end
      end

      // sift up: fetch the parent, or settle at the root
      S_SU_ISSUE: begin
        if (p > imhq_pkg::pos_t'(1)) begin
          heap_ra_a  = par_m1[imhq_pkg::VTX_BITS-1:0];
          state_next = S_SU_CMP;
        end else begin
          heap_we    = 1'b1;
          heap_wa    = p_m1[imhq_pkg::VTX_BITS-1:0];
          heap_wd    = '{vtx: vtx_r, key: nd_r};
          pos_we     = 1'b1;
          pos_wa     = vtx_r;
          pos_wd     = p;
          state_next = S_DONE;
        end
      end

      // sift up: pull the parent down or settle
      S_SU_CMP: begin
        heap_we = 1'b1;
        heap_wa = p_m1[imhq_pkg::VTX_BITS-1:0];
        pos_we  = 1'b1;
        pos_wd  = p;
        if (nd_r < heap_rd_a.key) begin
          heap_wd    = heap_rd_a;
          pos_wa     = heap_rd_a.vtx;
          p_next     = par;
          state_next = S_SU_ISSUE;
        end else begin
          heap_wd    = '{vtx: vtx_r, key: nd_r};
          pos_wa     = vtx_r;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, datapath and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= '0;
      vcount    <= imhq_pkg::POS_MAX;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      size  <= size_next;
      if (cfg_we) begin
        vcount <= cfg_data;
      end
      if (state == S_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    op_r       <= op_r_next;
    vtx_r      <= vtx_r_next;
    nd_r       <= nd_r_next;
    p          <= p_next;
    cnt        <= cnt_next;
    last       <= last_next;
    res_status <= res_status_next;
    res_vtx    <= res_vtx_next;
    res_dist   <= res_dist_next;
    res_queued <= res_queued_next;
    if (state == S_DONE && rsp_free) begin
      rsp.status          <= res_status;
      rsp.result_vertex   <= res_vtx;
      rsp.result_distance <= res_dist;
      rsp.queued          <= res_queued;
      rsp.remaining       <= size;
    end
  end

endmodule
`default_nettype wire

FILE: sv/imhq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module imhq_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [2:0]                      rsp_status,
  input wire logic [imhq_pkg::VTX_BITS-1:0]   rsp_vertex,
  input wire logic                            rsp_queued,
  input wire logic [imhq_pkg::POS_BITS-1:0]   rsp_remaining
);

  // one item at a time: ready drops after an accept
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous item still in work");

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex))
    else $error("stalled response changed");

  // queue never holds more than its capacity
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_remaining <= imhq_pkg::POS_MAX)
    else $error("remaining above capacity");

  // empty fault only with nothing queued
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == imhq_pkg::ST_EMPTY |-> rsp_remaining == '0)
    else $error("empty status with entries left");

  // a queued vertex comes only from a lookup or decrease that found it
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_queued |->
      (rsp_status == imhq_pkg::ST_OK || rsp_status == imhq_pkg::ST_NOT_DEC)
      && rsp_remaining != '0)
    else $error("queued flag with a fault status or empty queue");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_vertex    (rsp.result_vertex),
  .rsp_queued    (rsp.queued),
  .rsp_remaining (rsp.remaining)
);
`default_nettype wire

FILE: bench/imhq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_heap_checker
// Watches the request, response and register ports of the heap queue, keeps
// its own indexed min-heap with position map, and checks every response item
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module imhq_heap_checker
  import imhq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  pos_t       cfg_data,
  imhq_req_if        req,
  imhq_rsp_if        rsp,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  // one predicted response item
  typedef struct packed {
    status_t status;
    vtx_t    vertex;
    dist_t   distance;
    logic    queued;
    pos_t    remaining;
  } outcome_t;

  heap_entry_t slots [MAX_VERTICES];
  pos_t        where [MAX_VERTICES];
  pos_t        heap_len;
  pos_t        vtx_count;
  outcome_t    due_results [$];
  int          mismatches;

  // heap positions are 1-based
  function automatic dist_t key_at(int p);
    return slots[p-1].key;
  endfunction

  function automatic void put_at(int p, heap_entry_t e);
    slots[p-1] = e;
    where[e.vtx] = pos_t'(p);
  endfunction

  // apply one request to the shadow heap and return its response item
  function automatic outcome_t heap_apply(op_t op, vtx_t v, dist_t nd);
    outcome_t    o;
    heap_entry_t top_e;
    heap_entry_t last_e;
    heap_entry_t moved;
    int          lim;
    int          p;
    int          c;
    bit          done;
    lim = (vtx_count > POS_MAX) ? MAX_VERTICES : int'(vtx_count);
    o.status   = ST_OK;
    o.vertex   = v;
    o.distance = DIST_INF;
    o.queued   = 1'b0;
    if (op == OP_RESTART) begin
      o.vertex = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (i < lim) begin
          moved.vtx = vtx_t'(i);
          moved.key = DIST_INF;
          put_at(i + 1, moved);
        end else begin
          where[i] = '0;
        end
      end
      heap_len = pos_t'(lim);
    end else if (op == OP_REMOVE) begin
      o.vertex = '0;
      if (heap_len == 0) begin
        o.status = ST_EMPTY;
      end else begin
        top_e = slots[0];
        where[top_e.vtx] = '0;
        last_e = slots[int'(heap_len) - 1];
        heap_len = heap_len - pos_t'(1);
        // sift the last entry down from the root
        if (heap_len > 0) begin
          p = 1;
          done = 1'b0;
          while (!done && 2 * p <= int'(heap_len)) begin
            c = 2 * p;
            if (c + 1 <= int'(heap_len) && key_at(c + 1) < key_at(c))
              c = c + 1;
            if (key_at(c) < last_e.key) begin
              put_at(p, slots[c-1]);
              p = c;
            end else begin
              done = 1'b1;
            end
          end
          put_at(p, last_e);
        end
        o.vertex   = top_e.vtx;
        o.distance = top_e.key;
      end
    end else if (int'(v) >= lim) begin
      o.status = ST_RANGE;
    end else begin
      p = int'(where[v]);
      if (p == 0 || p > int'(heap_len)) begin
        o.status = (op == OP_DECREASE) ? ST_NOT_QUEUED : ST_OK;
      end else if (op == OP_LOOKUP) begin
        o.distance = key_at(p);
        o.queued   = 1'b1;
      end else if (nd > key_at(p)) begin
        o.status   = ST_NOT_DEC;
        o.distance = key_at(p);
        o.queued   = 1'b1;
      end else begin
        // sift up past strictly larger parents
        while (p > 1 && nd < key_at(p / 2)) begin
          put_at(p, slots[p/2 - 1]);
          p = p / 2;
        end
        moved.vtx = v;
        moved.key = nd;
        put_at(p, moved);
        o.distance = nd;
        o.queued   = 1'b1;
      end
    end
    o.remaining = heap_len;
    return o;
  endfunction

  // sample all ports at the rising edge
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) where[i] = '0;
      heap_len   = '0;
      vtx_count  = POS_MAX;
      due_results.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      mismatches = 0;
    end else begin
      // response item against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got.status    = rsp.status;
        got.vertex    = rsp.result_vertex;
        got.distance  = rsp.result_distance;
        got.queued    = rsp.queued;
        got.remaining = rsp.remaining;
        checked++;
        if (due_results.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response item with none expected: %s%0d v=%0d d=%h q=%0b n=%0d",
                     $realtime, "st=", got.status, got.vertex, got.distance,
                     got.queued, got.remaining);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp st=%0d v=%0d d=%h q=%0b n=%0d",
                       $realtime, want.status, want.vertex, want.distance,
                       want.queued, want.remaining);
              $display("%0t:          got st=%0d v=%0d d=%h q=%0b n=%0d",
                       $realtime, got.status, got.vertex, got.distance,
                       got.queued, got.remaining);
            end
          end
        end
      end
      // request item into the shadow heap, with the register as it was
      if (req.valid && req.ready)
        due_results.push_back(heap_apply(req.op, req.vertex, req.new_distance));
      // a register write takes effect after this edge
      if (cfg_we) vtx_count = cfg_data;
      pending = due_results.size();
    end
  end

endmodule

FILE: bench/indexed_min_heap_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test
// Drives the heap queue with a directed opening and then random search-like
// phases (restart, decrease key, remove nearest, lookup, plus noise) under
// several vertex_count settings, with random idling on both channels. The
// checker beside the block predicts and compares every response item.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_test;
  import imhq_pkg::*;

  localparam int RANDOM_ITEMS = 800;

  logic clk;
  logic rst;
  logic cfg_we;
  pos_t cfg_data;
  int   fail_count;
  int   pending;
  int   checked;
  int   sent;
  int   settings;
  bit   calm;

  imhq_req_if req_ch ();
  imhq_rsp_if rsp_ch ();

  indexed_min_heap_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  imhq_heap_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side: random stall bursts unless calm
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // send one request item; called and returns at a falling edge
  task automatic issue(op_t op, vtx_t v, dist_t d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.vertex       <= v;
    req_ch.new_distance <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // write vertex_count once the queue is idle
  task automatic set_count(pos_t val);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  // stimulus
  initial begin
    int    lim;
    int    n_ops;
    int    pick;
    int    r;
    bit    mid_cfg;
    dist_t span;
    dist_t d;
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_RESTART;
    req_ch.vertex       = '0;
    req_ch.new_distance = '0;
    calm                = 1'b0;
    sent                = 0;
    settings            = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue after reset
    issue(OP_LOOKUP, 8'd0, '0);
    issue(OP_REMOVE, 8'd0, '0);
    issue(OP_DECREASE, 8'd5, 32'd10);
    // small queue: range, ties, increase, equal keys
    set_count(9'd4);
    issue(OP_RESTART, 8'd0, '0);
    issue(OP_LOOKUP, 8'd3, '0);
    issue(OP_LOOKUP, 8'd4, '0);
    issue(OP_DECREASE, 8'd255, 32'd1);
    issue(OP_DECREASE, 8'd2, 32'd0);
    issue(OP_DECREASE, 8'd3, 32'd0);
    issue(OP_DECREASE, 8'd3, 32'd5);
    issue(OP_DECREASE, 8'd3, 32'd0);
    issue(OP_DECREASE, 8'd1, DIST_INF);
    issue(OP_DECREASE, 8'd0, 32'hFFFF_FFFE);
    repeat (5) issue(OP_REMOVE, 8'd0, '0);
    // zero count loads nothing
    set_count(9'd0);
    issue(OP_RESTART, 8'd0, '0);
    issue(OP_REMOVE, 8'd0, '0);
    issue(OP_LOOKUP, 8'd0, '0);
    // count above the maximum loads the full queue
    set_count(9'h1FF);
    issue(OP_RESTART, 8'd0, '0);
    issue(OP_DECREASE, 8'd255, 32'd7);
    issue(OP_DECREASE, 8'd128, 32'h8000_0000);
    issue(OP_LOOKUP, 8'd128, '0);
    issue(OP_REMOVE, 8'd0, '0);
    issue(OP_REMOVE, 8'd0, '0);

    // random search-like phases
    r = sent;
    while (sent < r + RANDOM_ITEMS) begin
      calm = (sent >= r + RANDOM_ITEMS - 120) || ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0)      lim = 0;
      else if (pick == 1) lim = $urandom_range(256, 511);
      else if (pick <= 3) lim = $urandom_range(17, 256);
      else                lim = $urandom_range(1, 16);
      set_count(pos_t'(lim));
      if (lim > MAX_VERTICES) lim = MAX_VERTICES;
      issue(OP_RESTART, vtx_t'($urandom_range(0, 255)), $urandom());
      case ($urandom_range(0, 3))
        0:       span = 32'h0000_0003;
        1:       span = 32'h0000_00FF;
        2:       span = 32'h000F_FFFF;
        default: span = 32'hFFFF_FFFF;
      endcase
      n_ops   = (lim == 0) ? 3 : $urandom_range(lim, 3 * lim);
      if (n_ops > 60) n_ops = 60;
      mid_cfg = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_ops; i++) begin
        // a register change mid-phase moves the range check only
        if (mid_cfg && i == n_ops / 2)
          set_count(pos_t'($urandom_range(0, 300)));
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? DIST_INF : ($urandom() & span);
        if (pick < 45 && lim > 0)
          issue(OP_DECREASE, vtx_t'($urandom_range(0, lim - 1)), d);
        else if (pick < 70)
          issue(OP_REMOVE, vtx_t'($urandom_range(0, 255)), $urandom());
        else if (pick < 85 && lim > 0)
          issue(OP_LOOKUP, vtx_t'($urandom_range(0, lim - 1)), $urandom());
        else
          issue(op_t'($urandom_range(0, 3)), vtx_t'($urandom_range(0, 255)), $urandom());
      end
      // drain small queues down to empty
      if (lim <= 16)
        repeat (lim + 1) issue(OP_REMOVE, vtx_t'($urandom_range(0, 255)), $urandom());
    end

    // wait for the last response items
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("run covered %0d request items and %0d checked responses", sent, checked);
    $display("over %0d vertex_count settings, with and without channel stalls", settings);
    if (fail_count == 0) begin
      $display("** indexed_min_heap_queue: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** indexed_min_heap_queue: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("timeout: queue stopped making progress");
    $display("** indexed_min_heap_queue: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
sv/imhq_pkg.sv
sv/imhq_req_if.sv
sv/imhq_rsp_if.sv
sv/indexed_min_heap_queue.sv
sv/imhq_checker.sv
bench/imhq_heap_checker.sv
bench/indexed_min_heap_queue_test.sv
